// ===== hw/rtl/rcf_pkg.sv =====
// Shared constants, types and kernel tables of the 3x3 RGB convolution filter.
package rcf_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int WIDTH_CFG_W  = 11;
   localparam int HEIGHT_CFG_W = 13;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 13;
   localparam int CHAN_W       = 8;
   localparam int PIX_W        = 3 * CHAN_W;
   localparam int MIN_SIZE     = 3;
   localparam int SUM_W        = 14;
   localparam int MAG_W        = SUM_W - 1;
   localparam int RECIP9       = 3641;
   localparam int RECIP_W      = 12;
   localparam int RECIP9_SHIFT = 15;
   localparam int PROD_W       = MAG_W + RECIP_W;
   localparam int BOX_BIAS     = 4;
   localparam int GAUSS_BIAS   = 8;
   localparam int GAUSS_SHIFT  = 4;
   localparam int CHAN_MAX     = 255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_MODE   = 3'd0,
      CSR_IMAGE_WIDTH   = 3'd1,
      CSR_IMAGE_HEIGHT  = 3'd2,
      CSR_USE_SELECTION = 3'd3,
      CSR_SEL_LEFT      = 3'd4,
      CSR_SEL_RIGHT     = 3'd5,
      CSR_SEL_TOP       = 3'd6,
      CSR_SEL_BOTTOM    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_SHARPEN = 2'd0,
      MODE_EDGE    = 2'd1,
      MODE_BOX     = 2'd2,
      MODE_GAUSS   = 2'd3
   } mode_type;

   typedef logic [CHAN_W-1:0]             chan_type;
   typedef logic [PIX_W-1:0]              pix_type;
   typedef logic [COL_W-1:0]              col_type;
   typedef logic [ROW_W-1:0]              row_type;
   typedef logic [2:0][2:0][CHAN_W-1:0]   chan_win_type;
   typedef logic signed [SUM_W-1:0]       sum_type;
   typedef logic signed [4:0]             weight_type;
   typedef logic [MAG_W-1:0]              mag_type;

   localparam weight_type KERNELS [4][3][3] = '{
      '{'{ 5'sd0, -5'sd1,  5'sd0}, '{-5'sd1,  5'sd5, -5'sd1}, '{ 5'sd0, -5'sd1,  5'sd0}},
      '{'{-5'sd1, -5'sd1, -5'sd1}, '{-5'sd1,  5'sd8, -5'sd1}, '{-5'sd1, -5'sd1, -5'sd1}},
      '{'{ 5'sd1,  5'sd1,  5'sd1}, '{ 5'sd1,  5'sd1,  5'sd1}, '{ 5'sd1,  5'sd1,  5'sd1}},
      '{'{ 5'sd1,  5'sd2,  5'sd1}, '{ 5'sd2,  5'sd4,  5'sd2}, '{ 5'sd1,  5'sd2,  5'sd1}}
   };

   typedef struct packed {
      logic    rd_en;
      col_type rd_idx;
      logic    wr_en;
      col_type wr_idx;
   } lb_ctl_type;

   typedef struct packed {
      logic     sum_en;
      logic     res_en;
      mode_type mode;
   } lane_ctl_type;

   function automatic chan_type sat_chan(input mag_type value);
      chan_type result;
      if (value > MAG_W'(CHAN_MAX)) begin
         result = CHAN_W'(CHAN_MAX);
      end else begin
         result = value[CHAN_W-1:0];
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/rcf_req_if.sv =====
// Input pixel channel: valid/ready handshake with one RGB pixel and a frame marker.
interface rcf_req_if;
   logic               valid;
   logic               ready;
   rcf_pkg::chan_type  red_in;
   rcf_pkg::chan_type  green_in;
   rcf_pkg::chan_type  blue_in;
   logic               frame_start;

   modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

// ===== hw/rtl/rcf_rsp_if.sv =====
// Result channel: valid/ready handshake with the emitted centre pixel and its position.
interface rcf_rsp_if;
   logic               valid;
   logic               ready;
   rcf_pkg::row_type   out_row;
   rcf_pkg::col_type   out_col;
   rcf_pkg::chan_type  red_out;
   rcf_pkg::chan_type  green_out;
   rcf_pkg::chan_type  blue_out;
   logic               was_filtered;

   modport source (output valid, out_row, out_col, red_out, green_out, blue_out, was_filtered,
                   input ready);
   modport sink   (input valid, out_row, out_col, red_out, green_out, blue_out, was_filtered,
                   output ready);
endinterface

// ===== hw/rtl/rcf_line_buffer.sv =====
// Two row memories with registered read and same-column forwarding.
module rcf_line_buffer (
   input  logic                clock,
   input  logic                reset,
   input  rcf_pkg::lb_ctl_type ctl,
   input  rcf_pkg::pix_type    wr_pix,
   output rcf_pkg::pix_type    up_pix,
   output rcf_pkg::pix_type    mid_pix
);

   rcf_pkg::pix_type upper_mem  [rcf_pkg::MAX_WIDTH];
   rcf_pkg::pix_type middle_mem [rcf_pkg::MAX_WIDTH];

   rcf_pkg::pix_type up_rd_ff;
   rcf_pkg::pix_type mid_rd_ff;
   rcf_pkg::pix_type fwd_up_ff;
   rcf_pkg::pix_type fwd_mid_ff;
   logic             fwd_ff;
   logic             fwd_in;

   assign fwd_in  = ctl.wr_en && (ctl.wr_idx == ctl.rd_idx);
   assign up_pix  = fwd_ff ? fwd_up_ff  : up_rd_ff;
   assign mid_pix = fwd_ff ? fwd_mid_ff : mid_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         upper_mem[ctl.wr_idx]  <= mid_pix;
         middle_mem[ctl.wr_idx] <= wr_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         up_rd_ff   <= upper_mem[ctl.rd_idx];
         mid_rd_ff  <= middle_mem[ctl.rd_idx];
         fwd_up_ff  <= mid_pix;
         fwd_mid_ff <= wr_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

endmodule

// ===== hw/rtl/rcf_lane.sv =====
// One color lane: kernel sum stage followed by clamp, divide and saturate stage.
module rcf_lane (
   input  logic                  clock,
   input  rcf_pkg::lane_ctl_type ctl,
   input  rcf_pkg::chan_win_type win,
   output rcf_pkg::chan_type     result
);

   rcf_pkg::sum_type  sum_ff;
   rcf_pkg::sum_type  sum_in;
   rcf_pkg::chan_type res_ff;
   rcf_pkg::chan_type res_in;

   always_comb begin
      rcf_pkg::sum_type acc [4];
      for (int m = 0; m < 4; m++) begin
         acc[m] = '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               acc[m] = acc[m] + rcf_pkg::sum_type'(win[i][j])
                               * rcf_pkg::sum_type'(rcf_pkg::KERNELS[m][i][j]);
            end
         end
      end
      sum_in = acc[ctl.mode];
   end

   always_comb begin
      rcf_pkg::mag_type             mag;
      rcf_pkg::mag_type             box_v;
      rcf_pkg::mag_type             gauss_v;
      logic [rcf_pkg::PROD_W-1:0]   prod;
      mag     = sum_ff[rcf_pkg::SUM_W-1] ? '0 : sum_ff[rcf_pkg::MAG_W-1:0];
      box_v   = mag + rcf_pkg::MAG_W'(rcf_pkg::BOX_BIAS);
      gauss_v = mag + rcf_pkg::MAG_W'(rcf_pkg::GAUSS_BIAS);
      prod    = rcf_pkg::PROD_W'(box_v) * rcf_pkg::PROD_W'(rcf_pkg::RECIP9);
      case (ctl.mode)
         rcf_pkg::MODE_BOX: begin
            res_in = rcf_pkg::sat_chan(rcf_pkg::MAG_W'(prod[rcf_pkg::PROD_W-1:rcf_pkg::RECIP9_SHIFT]));
         end
         rcf_pkg::MODE_GAUSS: begin
            res_in = rcf_pkg::sat_chan(gauss_v >> rcf_pkg::GAUSS_SHIFT);
         end
         default: begin
            res_in = rcf_pkg::sat_chan(mag);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
      if (ctl.res_en) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ===== hw/rtl/rgb_conv3x3_filter_core.sv =====
// Top level of the 3x3 RGB convolution filter: position tracking, window, lanes and merge.
//
// Pixels enter on req_chan in raster order, one item per clock at full rate while it is ready.
// frame_start on an item places it at row 0, column 0. Every item at row >= 2
// and column >= 2 produces one item on rsp_chan for the centre pixel one row
// up and one column left; all other items produce none. Border pixels never come out.
// A result passes the line memory read, window, kernel sum, divide/saturate and
// output registers before it is valid on rsp_chan. Throughput: one item per cycle
// while rsp_chan is ready, set by the line memories, which read and write together,
// and the three color lanes running side by side. Stalls: each stage holds its item
// while the next is full, but the window stage never holds an item that produces no
// result; empty stages keep filling, so req_chan stays ready until the whole pipeline
// is full. Configuration is written through csr_we/csr_index/csr_wdata, and the user
// must write it only while no items are in flight; the block does not enforce this.
// Reset clears the registers, the position and the pipeline; the line memories
// are not cleared and are filled by the first two rows.
module rgb_conv3x3_filter_core (
   input  logic                               clock,
   input  logic                               reset,
   rcf_req_if.sink                            req_chan,
   rcf_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [rcf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rcf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef struct packed {
      logic             emit;
      logic             in_region;
      rcf_pkg::row_type row;
      rcf_pkg::col_type col;
   } meta_type;

   localparam int WW = rcf_pkg::WIDTH_CFG_W;
   localparam int HW = rcf_pkg::HEIGHT_CFG_W;

   rcf_pkg::mode_type  filter_mode_ff;
   logic [WW-1:0]      image_width_ff;
   logic [HW-1:0]      image_height_ff;
   logic               use_selection_ff;
   logic [WW-1:0]      sel_left_ff;
   logic [WW-1:0]      sel_right_ff;
   logic [HW-1:0]      sel_top_ff;
   logic [HW-1:0]      sel_bottom_ff;

   rcf_pkg::col_type   col_ff;
   rcf_pkg::col_type   col_in;
   rcf_pkg::row_type   row_ff;
   rcf_pkg::row_type   row_in;

   logic               s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, out_v_ff;
   meta_type           s1_meta_ff, s2_meta_ff, s3_meta_ff, s4_meta_ff, out_meta_ff;
   meta_type           s1_meta_in;
   rcf_pkg::pix_type   s1_pix_ff;
   rcf_pkg::col_type   s1_idx_ff;
   rcf_pkg::col_type   idx_in;
   rcf_pkg::pix_type   win_ff [3][3];
   rcf_pkg::pix_type   s3_centre_ff, s4_centre_ff;
   rcf_pkg::pix_type   out_pix_ff;
   rcf_pkg::pix_type   req_pix;
   rcf_pkg::pix_type   up_pix, mid_pix;

   logic               accept;
   logic               out_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
   logic               s1_adv, s2_fwd, s3_adv, s4_adv;

   rcf_pkg::lb_ctl_type   lb_ctl;
   rcf_pkg::lane_ctl_type lane_ctl;
   rcf_pkg::chan_win_type lane_win [3];
   rcf_pkg::chan_type     lane_res [3];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff   <= rcf_pkg::MODE_SHARPEN;
         image_width_ff   <= WW'(rcf_pkg::MAX_WIDTH);
         image_height_ff  <= HW'(rcf_pkg::MAX_HEIGHT);
         use_selection_ff <= 1'b0;
         sel_left_ff      <= '0;
         sel_right_ff     <= '0;
         sel_top_ff       <= '0;
         sel_bottom_ff    <= '0;
      end else if (csr_we) begin
         case (rcf_pkg::csr_index_type'(csr_index))
            rcf_pkg::CSR_FILTER_MODE:   filter_mode_ff   <= rcf_pkg::mode_type'(csr_wdata[1:0]);
            rcf_pkg::CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[WW-1:0];
            rcf_pkg::CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata[HW-1:0];
            rcf_pkg::CSR_USE_SELECTION: use_selection_ff <= csr_wdata[0];
            rcf_pkg::CSR_SEL_LEFT:      sel_left_ff      <= csr_wdata[WW-1:0];
            rcf_pkg::CSR_SEL_RIGHT:     sel_right_ff     <= csr_wdata[WW-1:0];
            rcf_pkg::CSR_SEL_TOP:       sel_top_ff       <= csr_wdata[HW-1:0];
            rcf_pkg::CSR_SEL_BOTTOM:    sel_bottom_ff    <= csr_wdata[HW-1:0];
            default: begin
            end
         endcase
      end
   end

   // position of the incoming item and the region test for its centre
   always_comb begin
      logic [WW-1:0] w_eff, c_ext, c_next, cc_ext, x1, x2;
      logic [HW-1:0] h_eff, r_ext, r_next, cr_ext, y1, y2;
      rcf_pkg::col_type c_base;
      rcf_pkg::row_type r_base;
      if (image_width_ff < WW'(rcf_pkg::MIN_SIZE)) begin
         w_eff = WW'(rcf_pkg::MIN_SIZE);
      end else if (image_width_ff > WW'(rcf_pkg::MAX_WIDTH)) begin
         w_eff = WW'(rcf_pkg::MAX_WIDTH);
      end else begin
         w_eff = image_width_ff;
      end
      if (image_height_ff < HW'(rcf_pkg::MIN_SIZE)) begin
         h_eff = HW'(rcf_pkg::MIN_SIZE);
      end else if (image_height_ff > HW'(rcf_pkg::MAX_HEIGHT)) begin
         h_eff = HW'(rcf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = image_height_ff;
      end
      c_base = req_chan.frame_start ? '0 : col_ff;
      r_base = req_chan.frame_start ? '0 : row_ff;
      c_ext  = (WW'(c_base) >= w_eff) ? '0 : WW'(c_base);
      r_ext  = (HW'(r_base) >= h_eff) ? '0 : HW'(r_base);
      cc_ext = c_ext - WW'(1);
      cr_ext = r_ext - HW'(1);
      x1 = (sel_left_ff == '0) ? WW'(1) : sel_left_ff;
      y1 = (sel_top_ff == '0)  ? HW'(1) : sel_top_ff;
      x2 = (sel_right_ff == w_eff)  ? w_eff - WW'(1) : sel_right_ff;
      y2 = (sel_bottom_ff == h_eff) ? h_eff - HW'(1) : sel_bottom_ff;

      s1_meta_in.emit      = (c_ext >= WW'(2)) && (r_ext >= HW'(2));
      s1_meta_in.in_region = !use_selection_ff ||
                             ((cc_ext >= x1) && (cc_ext < x2) && (cr_ext >= y1) && (cr_ext < y2));
      s1_meta_in.row       = cr_ext[rcf_pkg::ROW_W-1:0];
      s1_meta_in.col       = cc_ext[rcf_pkg::COL_W-1:0];
      idx_in               = c_ext[rcf_pkg::COL_W-1:0];

      c_next = c_ext + WW'(1);
      r_next = r_ext + HW'(1);
      if (c_next >= w_eff) begin
         col_in = '0;
         row_in = (r_next >= h_eff) ? '0 : r_next[rcf_pkg::ROW_W-1:0];
      end else begin
         col_in = c_next[rcf_pkg::COL_W-1:0];
         row_in = r_ext[rcf_pkg::ROW_W-1:0];
      end
   end

   // pipeline handshake
   assign out_rdy = !out_v_ff || rsp_chan.ready;
   assign s4_rdy  = !s4_v_ff || out_rdy;
   assign s3_rdy  = !s3_v_ff || s4_rdy;
   assign s2_rdy  = !s2_v_ff || !s2_meta_ff.emit || s3_rdy;
   assign s1_rdy  = !s1_v_ff || s2_rdy;

   assign req_chan.ready = s1_rdy;
   assign accept  = req_chan.valid && s1_rdy;
   assign s1_adv  = s1_v_ff && s2_rdy;
   assign s2_fwd  = s2_v_ff && s2_meta_ff.emit && s3_rdy;
   assign s3_adv  = s3_v_ff && s4_rdy;
   assign s4_adv  = s4_v_ff && out_rdy;

   assign req_pix = {req_chan.red_in, req_chan.green_in, req_chan.blue_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         s1_v_ff  <= accept  || (s1_v_ff && !s2_rdy);
         s2_v_ff  <= s1_adv  || (s2_v_ff && !s2_rdy);
         s3_v_ff  <= s2_fwd  || (s3_v_ff && !s4_rdy);
         s4_v_ff  <= s3_adv  || (s4_v_ff && !out_rdy);
         out_v_ff <= s4_adv  || (out_v_ff && !rsp_chan.ready);
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // window shifts once per item as it leaves the read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_adv) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= up_pix;
         win_ff[1][2] <= mid_pix;
         win_ff[2][2] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
         s1_pix_ff  <= req_pix;
         s1_idx_ff  <= idx_in;
      end
      if (s1_adv) begin
         s2_meta_ff <= s1_meta_ff;
      end
      if (s2_fwd) begin
         s3_meta_ff   <= s2_meta_ff;
         s3_centre_ff <= win_ff[1][1];
      end
      if (s3_adv) begin
         s4_meta_ff   <= s3_meta_ff;
         s4_centre_ff <= s3_centre_ff;
      end
      if (s4_adv) begin
         out_meta_ff <= s4_meta_ff;
         out_pix_ff  <= s4_meta_ff.in_region ? {lane_res[0], lane_res[1], lane_res[2]}
                                             : s4_centre_ff;
      end
   end

   assign lb_ctl.rd_en  = accept;
   assign lb_ctl.rd_idx = idx_in;
   assign lb_ctl.wr_en  = s1_adv;
   assign lb_ctl.wr_idx = s1_idx_ff;

   rcf_line_buffer u_line_buffer (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lb_ctl),
      .wr_pix  (s1_pix_ff),
      .up_pix  (up_pix),
      .mid_pix (mid_pix)
   );

   assign lane_ctl.sum_en = s2_fwd;
   assign lane_ctl.res_en = s3_adv;
   assign lane_ctl.mode   = filter_mode_ff;

   // lane 0 red, lane 1 green, lane 2 blue
   for (genvar g = 0; g < 3; g++) begin : g_lane
      localparam int LSB = (2 - g) * rcf_pkg::CHAN_W;
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               lane_win[g][i][j] = win_ff[i][j][LSB +: rcf_pkg::CHAN_W];
            end
         end
      end
      rcf_lane u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .win    (lane_win[g]),
         .result (lane_res[g])
      );
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.out_row      = out_meta_ff.row;
   assign rsp_chan.out_col      = out_meta_ff.col;
   assign rsp_chan.red_out      = out_pix_ff[2*rcf_pkg::CHAN_W +: rcf_pkg::CHAN_W];
   assign rsp_chan.green_out    = out_pix_ff[rcf_pkg::CHAN_W +: rcf_pkg::CHAN_W];
   assign rsp_chan.blue_out     = out_pix_ff[0 +: rcf_pkg::CHAN_W];
   assign rsp_chan.was_filtered = out_meta_ff.in_region;

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

   a_no_border : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.out_row != '0) && (rsp_chan.out_col != '0))
      else $error("border pixel emitted");

   a_s2_hold : assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && s2_meta_ff.emit && !s3_rdy |=> s2_v_ff && s2_meta_ff.emit)
      else $error("stalled window item lost");

   a_s3_hold : assert property (@(posedge clock) disable iff (reset)
      s3_v_ff && !s4_rdy |=> s3_v_ff && $stable(s3_meta_ff))
      else $error("stalled sum item lost");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the 3x3 RGB convolution filter core.
module testbench;

   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      rcf_pkg::chan_type red;
      rcf_pkg::chan_type green;
      rcf_pkg::chan_type blue;
      logic              frame_start;
   } pixel_item_type;

   typedef struct {
      logic [rcf_pkg::ROW_W-1:0] row;
      logic [rcf_pkg::COL_W-1:0] col;
      rcf_pkg::chan_type         red;
      rcf_pkg::chan_type         green;
      rcf_pkg::chan_type         blue;
      logic                      filtered;
   } centre_item_type;

   class conv_scoreboard;
      rcf_pkg::mode_type                 mode;
      bit [rcf_pkg::WIDTH_CFG_W-1:0]     width_reg;
      bit [rcf_pkg::HEIGHT_CFG_W-1:0]    height_reg;
      bit                                use_sel;
      bit [rcf_pkg::WIDTH_CFG_W-1:0]     sel_left;
      bit [rcf_pkg::WIDTH_CFG_W-1:0]     sel_right;
      bit [rcf_pkg::HEIGHT_CFG_W-1:0]    sel_top;
      bit [rcf_pkg::HEIGHT_CFG_W-1:0]    sel_bottom;
      rcf_pkg::pix_type                  upper_line[rcf_pkg::MAX_WIDTH];
      rcf_pkg::pix_type                  middle_line[rcf_pkg::MAX_WIDTH];
      rcf_pkg::pix_type                  neighbours[3][3];
      int unsigned                       row_pos;
      int unsigned                       col_pos;
      centre_item_type                   expected_centres[$];
      int unsigned                       error_count;

      function new();
         mode = rcf_pkg::MODE_SHARPEN;
         width_reg = 11'd1024;
         height_reg = 13'd4096;
         use_sel = 1'b0;
         sel_left = '0;
         sel_right = '0;
         sel_top = '0;
         sel_bottom = '0;
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
         end
         foreach (neighbours[i, j]) neighbours[i][j] = '0;
         row_pos = 0;
         col_pos = 0;
         error_count = 0;
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         error_count++;
      endtask

      function void config_write(rcf_pkg::csr_index_type index,
                                 logic [rcf_pkg::CSR_DATA_W-1:0] data);
         case (index)
            rcf_pkg::CSR_FILTER_MODE:   mode = rcf_pkg::mode_type'(data[1:0]);
            rcf_pkg::CSR_IMAGE_WIDTH:   width_reg = data[rcf_pkg::WIDTH_CFG_W-1:0];
            rcf_pkg::CSR_IMAGE_HEIGHT:  height_reg = data[rcf_pkg::HEIGHT_CFG_W-1:0];
            rcf_pkg::CSR_USE_SELECTION: use_sel = data[0];
            rcf_pkg::CSR_SEL_LEFT:      sel_left = data[rcf_pkg::WIDTH_CFG_W-1:0];
            rcf_pkg::CSR_SEL_RIGHT:     sel_right = data[rcf_pkg::WIDTH_CFG_W-1:0];
            rcf_pkg::CSR_SEL_TOP:       sel_top = data[rcf_pkg::HEIGHT_CFG_W-1:0];
            rcf_pkg::CSR_SEL_BOTTOM:    sel_bottom = data[rcf_pkg::HEIGHT_CFG_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned active_width();
         if (width_reg < rcf_pkg::MIN_SIZE) return rcf_pkg::MIN_SIZE;
         if (width_reg > rcf_pkg::MAX_WIDTH) return rcf_pkg::MAX_WIDTH;
         return width_reg;
      endfunction

      function int unsigned active_height();
         if (height_reg < rcf_pkg::MIN_SIZE) return rcf_pkg::MIN_SIZE;
         if (height_reg > rcf_pkg::MAX_HEIGHT) return rcf_pkg::MAX_HEIGHT;
         return height_reg;
      endfunction

      function int kernel_weight(int i, int j);
         bit centre;
         bit axis;
         centre = (i == 1) && (j == 1);
         axis = (i == 1) || (j == 1);
         case (mode)
            rcf_pkg::MODE_SHARPEN: return centre ? 5 : (axis ? -1 : 0);
            rcf_pkg::MODE_EDGE:    return centre ? 8 : -1;
            rcf_pkg::MODE_BOX:     return 1;
            default:               return centre ? 4 : (axis ? 2 : 1);
         endcase
      endfunction

      function rcf_pkg::chan_type filter_lane(int shift);
         int sum;
         int unsigned mag;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               sum += int'(neighbours[i][j][shift +: rcf_pkg::CHAN_W]) * kernel_weight(i, j);
            end
         end
         if (sum < 0) sum = 0;
         mag = sum;
         if (mode == rcf_pkg::MODE_BOX) mag = (mag + 4) / 9;
         else if (mode == rcf_pkg::MODE_GAUSS) mag = (mag + 8) >> 4;
         if (mag > 255) mag = 255;
         return rcf_pkg::chan_type'(mag);
      endfunction

      function void accept_pixel(pixel_item_type p);
         int unsigned w;
         int unsigned h;
         int unsigned r;
         int unsigned c;
         int unsigned idx;
         int unsigned x1;
         int unsigned x2;
         int unsigned y1;
         int unsigned y2;
         rcf_pkg::pix_type pix;
         rcf_pkg::pix_type up;
         rcf_pkg::pix_type mid;
         bit in_region;
         centre_item_type res;
         w = active_width();
         h = active_height();
         pix = {p.red, p.green, p.blue};
         if (p.frame_start) begin
            row_pos = 0;
            col_pos = 0;
         end
         if (col_pos >= w) col_pos = 0;
         if (row_pos >= h) row_pos = 0;
         r = row_pos;
         c = col_pos;
         idx = c % rcf_pkg::MAX_WIDTH;
         up = upper_line[idx];
         mid = middle_line[idx];
         upper_line[idx] = mid;
         middle_line[idx] = pix;
         for (int i = 0; i < 3; i++) begin
            neighbours[i][0] = neighbours[i][1];
            neighbours[i][1] = neighbours[i][2];
         end
         neighbours[0][2] = up;
         neighbours[1][2] = mid;
         neighbours[2][2] = pix;
         if (r >= 2 && c >= 2) begin
            if (!use_sel) begin
               in_region = 1'b1;
            end else begin
               x1 = (sel_left != 0) ? sel_left : 1;
               y1 = (sel_top != 0) ? sel_top : 1;
               x2 = (sel_right == w) ? w - 1 : sel_right;
               y2 = (sel_bottom == h) ? h - 1 : sel_bottom;
               in_region = (c - 1 >= x1) && (c - 1 < x2) && (r - 1 >= y1) && (r - 1 < y2);
            end
            res.row = rcf_pkg::ROW_W'(r - 1);
            res.col = rcf_pkg::COL_W'(c - 1);
            if (in_region) begin
               res.red = filter_lane(16);
               res.green = filter_lane(8);
               res.blue = filter_lane(0);
            end else begin
               res.red = neighbours[1][1][23:16];
               res.green = neighbours[1][1][15:8];
               res.blue = neighbours[1][1][7:0];
            end
            res.filtered = in_region;
            expected_centres.push_back(res);
         end
         col_pos = c + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      task check_field(string name, logic [11:0] got, logic [11:0] want,
                       centre_item_type exp_c);
         if (got !== want) begin
            report($sformatf("%s got %0d expected %0d (centre row %0d col %0d)",
                             name, got, want, exp_c.row, exp_c.col));
         end
      endtask

      task check_centre(centre_item_type got);
         centre_item_type want;
         if (expected_centres.size() == 0) begin
            report($sformatf("unexpected result row %0d col %0d", got.row, got.col));
            return;
         end
         want = expected_centres.pop_front();
         check_field("out_row", got.row, want.row, want);
         check_field("out_col", got.col, want.col, want);
         check_field("red_out", got.red, want.red, want);
         check_field("green_out", got.green, want.green, want);
         check_field("blue_out", got.blue, want.blue, want);
         check_field("was_filtered", got.filtered, want.filtered, want);
      endtask

      task finish_check();
         if (expected_centres.size() != 0) begin
            report($sformatf("%0d expected results never arrived", expected_centres.size()));
         end
      endtask
   endclass

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   rcf_pkg::csr_index_type           csr_index;
   logic [rcf_pkg::CSR_DATA_W-1:0]   csr_wdata;
   bit                               idle_on;
   int unsigned                      results_seen;
   conv_scoreboard                   sb;

   rcf_req_if req_if();
   rcf_rsp_if rsp_if();

   rgb_conv3x3_filter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      centre_item_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.row = rsp_if.out_row;
         got.col = rsp_if.out_col;
         got.red = rsp_if.red_out;
         got.green = rsp_if.green_out;
         got.blue = rsp_if.blue_out;
         got.filtered = rsp_if.was_filtered;
         sb.check_centre(got);
         results_seen++;
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int unsigned stall;
      bit long_hold_done;
      stall = 0;
      long_hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall == 0) begin
            if (!long_hold_done && results_seen >= 50 && req_if.valid) begin
               stall = 80;
               long_hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
               stall = $urandom_range(1, 14);
            end
         end
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic write_csr(rcf_pkg::csr_index_type index,
                            logic [rcf_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      sb.config_write(index, data);
      @(negedge clock);
   endtask

   task automatic configure(rcf_pkg::mode_type m, int unsigned w, int unsigned h, bit sel,
                            int unsigned l, int unsigned r, int unsigned t, int unsigned b);
      write_csr(rcf_pkg::CSR_FILTER_MODE, rcf_pkg::CSR_DATA_W'(m));
      write_csr(rcf_pkg::CSR_IMAGE_WIDTH, rcf_pkg::CSR_DATA_W'(w));
      write_csr(rcf_pkg::CSR_IMAGE_HEIGHT, rcf_pkg::CSR_DATA_W'(h));
      write_csr(rcf_pkg::CSR_USE_SELECTION, rcf_pkg::CSR_DATA_W'(sel));
      write_csr(rcf_pkg::CSR_SEL_LEFT, rcf_pkg::CSR_DATA_W'(l));
      write_csr(rcf_pkg::CSR_SEL_RIGHT, rcf_pkg::CSR_DATA_W'(r));
      write_csr(rcf_pkg::CSR_SEL_TOP, rcf_pkg::CSR_DATA_W'(t));
      write_csr(rcf_pkg::CSR_SEL_BOTTOM, rcf_pkg::CSR_DATA_W'(b));
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_pixel(pixel_item_type p);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.red_in <= p.red;
      req_if.green_in <= p.green;
      req_if.blue_in <= p.blue;
      req_if.frame_start <= p.frame_start;
      do @(posedge clock); while (!req_if.ready);
      sb.accept_pixel(p);
      @(negedge clock);
   endtask

   task automatic send_rgb(int unsigned r, int unsigned g, int unsigned b, bit fs);
      pixel_item_type p;
      p.red = rcf_pkg::chan_type'(r);
      p.green = rcf_pkg::chan_type'(g);
      p.blue = rcf_pkg::chan_type'(b);
      p.frame_start = fs;
      send_pixel(p);
   endtask

   function automatic rcf_pkg::chan_type random_chan();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return rcf_pkg::chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_frame_run(int unsigned count, bit noisy);
      for (int unsigned k = 0; k < count; k++) begin
         send_rgb(random_chan(), random_chan(), random_chan(),
                  k == 0 || (noisy && $urandom_range(0, 59) == 0));
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.expected_centres.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic int unsigned pick_bound(int unsigned size, int unsigned full);
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return size;
         2:       return $urandom_range(0, full);
         default: return $urandom_range(0, size + 1);
      endcase
   endfunction

   initial begin
      int unsigned items_sent;
      int unsigned w;
      int unsigned h;
      int unsigned w_eff;
      int unsigned h_eff;
      int unsigned rows;
      int unsigned count;
      sb = new();
      results_seen = 0;
      idle_on = 1'b1;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = rcf_pkg::CSR_FILTER_MODE;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.red_in = '0;
      req_if.green_in = '0;
      req_if.blue_in = '0;
      req_if.frame_start = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sharpen with undersized frame: saturation, then a wrapped frame that clamps negative
      configure(rcf_pkg::MODE_SHARPEN, 0, 1, 1'b0, 0, 0, 0, 0);
      for (int k = 0; k < 9; k++) begin
         if (k == 4) send_rgb(255, 1, 51, k == 0);
         else send_rgb(0, 0, 0, k == 0);
      end
      drain();
      for (int k = 0; k < 9; k++) begin
         if (k == 4) send_rgb(0, 0, 0, 1'b0);
         else send_rgb(255, 255, 255, 1'b0);
      end
      drain();

      // gaussian over a selection that touches every edge, restarted mid-frame
      configure(rcf_pkg::MODE_GAUSS, 3, 3, 1'b1, 0, 3, 0, 3);
      send_rgb(17, 200, 3, 1'b1);
      send_rgb(90, 0, 255, 1'b0);
      for (int k = 0; k < 9; k++) send_rgb(255, 255, 255, k == 0);
      drain();

      items_sent = 0;
      while (items_sent < 1200) begin
         if (items_sent >= 1000) idle_on = 1'b0;
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 2);
            1:       w = $urandom_range(11, 40);
            default: w = $urandom_range(3, 10);
         endcase
         case ($urandom_range(0, 9))
            0:       h = $urandom_range(0, 2);
            1:       h = $urandom_range(4096, 8191);
            default: h = $urandom_range(3, 9);
         endcase
         w_eff = (w < rcf_pkg::MIN_SIZE) ? rcf_pkg::MIN_SIZE : w;
         h_eff = (h < rcf_pkg::MIN_SIZE) ? rcf_pkg::MIN_SIZE
               : ((h > rcf_pkg::MAX_HEIGHT) ? rcf_pkg::MAX_HEIGHT : h);
         configure(rcf_pkg::mode_type'($urandom_range(0, 3)), w, h, 1'($urandom_range(0, 1)),
                   pick_bound(w_eff, 2047), pick_bound(w_eff, 2047),
                   pick_bound(h_eff, 8191), pick_bound(h_eff, 8191));
         rows = $urandom_range(3, ((h_eff < 8) ? h_eff : 8) + 2);
         count = rows * w_eff + $urandom_range(0, w_eff - 1);
         send_frame_run(count, 1'b1);
         items_sent += count;
         drain();
      end

      sb.finish_check();
      if (sb.error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/rcf_pkg.sv
hw/rtl/rcf_req_if.sv
hw/rtl/rcf_rsp_if.sv
hw/rtl/rcf_line_buffer.sv
hw/rtl/rcf_lane.sv
hw/rtl/rgb_conv3x3_filter_core.sv
sim/testbench.sv
